/* hw/rtl/sjafk_pkg.sv */
// ----------------------------------------------------------------------------
// sjafk_pkg: shared types and constants for the arm forward kinematics block.
// Holds the joint/pose beat structs, the Q.28 constants and the atan table.
// ----------------------------------------------------------------------------
package sjafk_pkg;

  localparam int FRAC = 28;
  localparam int NSTEP = 20;
  localparam int NJ = 7;
  localparam int XW = 32;

  localparam logic signed [XW-1:0] ONE = 32'sd268435456;
  localparam logic signed [XW-1:0] PI_Q = 32'sd843314857;
  localparam logic signed [XW-1:0] HPI_Q = 32'sd421657428;
  localparam logic signed [XW-1:0] GAIN_Q = 32'sd163008219;
  localparam logic signed [XW-1:0] DP1 = 32'sd38117835;
  localparam logic signed [XW-1:0] DP2 = 32'sd51271172;
  localparam logic signed [XW-1:0] DP3 = 32'sd52076478;
  localparam logic signed [XW-1:0] DP4 = 32'sd32749126;
  localparam logic signed [XW-1:0] AP4 = 32'sd22145925;
  localparam logic signed [XW-1:0] DP5 = 32'sd36507222;
  localparam logic signed [XW-1:0] DP6 = 32'sd66571993;
  localparam logic signed [XW-1:0] AP6 = 32'sd23622320;
  localparam logic signed [XW-1:0] DP7 = 32'sd28722594;
  localparam logic signed [XW-1:0] HS2 = 32'sd189812536;
  localparam logic signed [XW-1:0] FLIFT = 32'sd15676631;

  typedef struct packed {
    logic signed [15:0] joint_angle_1;
    logic signed [15:0] joint_angle_2;
    logic signed [15:0] joint_angle_3;
    logic signed [15:0] joint_angle_4;
    logic signed [15:0] joint_angle_5;
    logic signed [15:0] joint_angle_6;
    logic signed [15:0] joint_angle_7;
  } joints_t;

  typedef struct packed {
    logic signed [15:0] rot_xx;
    logic signed [15:0] rot_xy;
    logic signed [15:0] rot_xz;
    logic signed [15:0] rot_yx;
    logic signed [15:0] rot_yy;
    logic signed [15:0] rot_yz;
    logic signed [15:0] rot_zx;
    logic signed [15:0] rot_zy;
    logic signed [15:0] rot_zz;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } pose_t;

  // one CORDIC lane in flight
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] z;
    logic flip;
  } lane_t;

  typedef logic signed [XW-1:0] mat_t [3][4];

  function automatic logic signed [XW-1:0] atan_q(input int i);
    logic signed [XW-1:0] r;
    case (i)
      0: r = 32'sd210828714;
      1: r = 32'sd124459457;
      2: r = 32'sd65760959;
      3: r = 32'sd33381290;
      4: r = 32'sd16755422;
      5: r = 32'sd8385879;
      6: r = 32'sd4193963;
      7: r = 32'sd2097109;
      8: r = 32'sd1048571;
      9: r = 32'sd524287;
      10: r = 32'sd262144;
      11: r = 32'sd131072;
      12: r = 32'sd65536;
      13: r = 32'sd32768;
      14: r = 32'sd16384;
      15: r = 32'sd8192;
      16: r = 32'sd4096;
      17: r = 32'sd2048;
      18: r = 32'sd1024;
      default: r = 32'sd512;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/sjafk_cordic_cell.sv */
// ----------------------------------------------------------------------------
// sjafk_cordic_cell: one CORDIC micro-rotation for all seven joints.
// Registered; hands the lanes to the next cell every cycle.
// ----------------------------------------------------------------------------
module sjafk_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            vin,
  input  sjafk_pkg::lane_t lin [sjafk_pkg::NJ],
  output logic            vout,
  output sjafk_pkg::lane_t lout [sjafk_pkg::NJ]
);

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < sjafk_pkg::NJ; j++) begin
      lout[j].flip <= lin[j].flip;
      if (!lin[j].z[sjafk_pkg::XW-1]) begin
        lout[j].x <= lin[j].x - (lin[j].y >>> STEP);
        lout[j].y <= lin[j].y + (lin[j].x >>> STEP);
        lout[j].z <= lin[j].z - sjafk_pkg::atan_q(STEP);
      end else begin
        lout[j].x <= lin[j].x + (lin[j].y >>> STEP);
        lout[j].y <= lin[j].y - (lin[j].x >>> STEP);
        lout[j].z <= lin[j].z + sjafk_pkg::atan_q(STEP);
      end
    end
  end

endmodule

/* hw/rtl/sjafk_link_cell.sv */
// ----------------------------------------------------------------------------
// sjafk_link_cell: multiplies the running transform by one link matrix.
// Two stages: products registered, then sum, round and add translation.
// ----------------------------------------------------------------------------
module sjafk_link_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               vin,
  input  sjafk_pkg::mat_t    tin,
  input  sjafk_pkg::mat_t    ain,
  output logic               vout,
  output sjafk_pkg::mat_t    tout
);

  logic v1;
  logic signed [63:0] prod [3][4][3];
  logic signed [31:0] tr [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      vout <= 1'b0;
    end else begin
      v1 <= vin;
      vout <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      tr[i] <= tin[i][3];
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          prod[i][j][k] <= 64'(tin[i][k]) * 64'(ain[k][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [65:0] acc;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = 66'(prod[i][j][0]) + 66'(prod[i][j][1]) + 66'(prod[i][j][2])
            + 66'sd134217728;
        if (j == 3) begin
          tout[i][j] <= 32'(acc >>> sjafk_pkg::FRAC) + tr[i];
        end else begin
          tout[i][j] <= 32'(acc >>> sjafk_pkg::FRAC);
        end
      end
    end
  end

endmodule

/* hw/rtl/seven_joint_arm_forward_kinematics.sv */
// ----------------------------------------------------------------------------
// seven_joint_arm_forward_kinematics: seven-joint arm pose pipeline.
// Pipeline from start to done (1 reduce, 20 CORDIC cells,
// 13 link cells of 2 stages, 1 output saturate). Throughput one beat per
// cycle: busy is never raised. Synchronous reset clears all valid bits;
// the receiver cannot stall, done pulses for one cycle per beat.
// ----------------------------------------------------------------------------
module seven_joint_arm_forward_kinematics (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sjafk_pkg::joints_t joints,
  output logic              done,
  output sjafk_pkg::pose_t  pose
);

  localparam int NL = 13;
  localparam int NJ = sjafk_pkg::NJ;

  sjafk_pkg::lane_t lanes [sjafk_pkg::NSTEP+1][NJ];
  logic cv [sjafk_pkg::NSTEP+1];
  logic signed [15:0] ang [NJ];
  logic signed [31:0] cs [NL][NJ];
  logic signed [31:0] sn [NL][NJ];
  sjafk_pkg::mat_t tm [NL+1];
  sjafk_pkg::mat_t am [NL];
  logic lv [NL+1];

  assign busy = 1'b0;
  assign ang[0] = joints.joint_angle_1;
  assign ang[1] = joints.joint_angle_2;
  assign ang[2] = joints.joint_angle_3;
  assign ang[3] = joints.joint_angle_4;
  assign ang[4] = joints.joint_angle_5;
  assign ang[5] = joints.joint_angle_6;
  assign ang[6] = joints.joint_angle_7;

  // range reduction into +-pi/2
  always_ff @(posedge clk) begin
    logic signed [31:0] z;
    for (int j = 0; j < NJ; j++) begin
      z = 32'({{16{ang[j][15]}}, ang[j]} <<< 15);
      lanes[0][j].x <= sjafk_pkg::GAIN_Q;
      lanes[0][j].y <= '0;
      if (z > sjafk_pkg::HPI_Q) begin
        lanes[0][j].z <= z - sjafk_pkg::PI_Q;
        lanes[0][j].flip <= 1'b1;
      end else if (z < -sjafk_pkg::HPI_Q) begin
        lanes[0][j].z <= z + sjafk_pkg::PI_Q;
        lanes[0][j].flip <= 1'b1;
      end else begin
        lanes[0][j].z <= z;
        lanes[0][j].flip <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= start && !busy;
    end
  end

  for (genvar g = 0; g < sjafk_pkg::NSTEP; g++) begin : g_cordic
    sjafk_cordic_cell #(.STEP(g)) u_cell (
      .clk (clk), .rst (rst), .vin (cv[g]), .lin (lanes[g]),
      .vout(cv[g+1]), .lout(lanes[g+1])
    );
  end

  always_comb begin
    for (int j = 0; j < NJ; j++) begin
      cs[0][j] = lanes[sjafk_pkg::NSTEP][j].flip ? -lanes[sjafk_pkg::NSTEP][j].x
                                                 : lanes[sjafk_pkg::NSTEP][j].x;
      sn[0][j] = lanes[sjafk_pkg::NSTEP][j].flip ? -lanes[sjafk_pkg::NSTEP][j].y
                                                 : lanes[sjafk_pkg::NSTEP][j].y;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        tm[0][i][j] = (i == j) ? sjafk_pkg::ONE : '0;
      end
    end
  end
  assign lv[0] = cv[sjafk_pkg::NSTEP];

  // carry sines and cosines alongside the link chain (2 stages per cell)
  for (genvar l = 0; l < NL; l++) begin : g_link
    logic signed [31:0] c0, s0, c1, s1, c2, s2, c3, s3, c4, s4, c5, s5, c6, s6;
    if (l < NL - 1) begin : g_carry
      logic signed [31:0] cd [NJ];
      logic signed [31:0] sd [NJ];
      always_ff @(posedge clk) begin
        cd <= cs[l];
        sd <= sn[l];
        cs[l+1] <= cd;
        sn[l+1] <= sd;
      end
    end
    assign c0 = cs[l][0]; assign s0 = sn[l][0];
    assign c1 = cs[l][1]; assign s1 = sn[l][1];
    assign c2 = cs[l][2]; assign s2 = sn[l][2];
    assign c3 = cs[l][3]; assign s3 = sn[l][3];
    assign c4 = cs[l][4]; assign s4 = sn[l][4];
    assign c5 = cs[l][5]; assign s5 = sn[l][5];
    assign c6 = cs[l][6]; assign s6 = sn[l][6];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 4; j++) begin
          am[l][i][j] = (i == j) ? sjafk_pkg::ONE : '0;
        end
      end
      case (l)
        0: am[l][2][3] = sjafk_pkg::DP1;
        1: begin
          am[l][0][0] = c0; am[l][0][1] = -s0;
          am[l][1][0] = s0; am[l][1][1] = c0; am[l][2][3] = sjafk_pkg::DP2;
        end
        2: begin
          am[l][0][0] = c1; am[l][0][1] = -s1;
          am[l][1][1] = '0; am[l][1][2] = sjafk_pkg::ONE;
          am[l][2][0] = -s1; am[l][2][1] = -c1; am[l][2][2] = '0;
        end
        3: am[l][1][3] = -sjafk_pkg::DP3;
        4: begin
          am[l][0][0] = c2; am[l][0][1] = -s2;
          am[l][1][1] = '0; am[l][1][2] = -sjafk_pkg::ONE; am[l][1][3] = -sjafk_pkg::DP4;
          am[l][2][0] = s2; am[l][2][1] = c2; am[l][2][2] = '0;
        end
        5: begin
          am[l][0][0] = c3; am[l][0][1] = -s3; am[l][0][3] = sjafk_pkg::AP4;
          am[l][1][1] = '0; am[l][1][2] = -sjafk_pkg::ONE;
          am[l][2][0] = s3; am[l][2][1] = c3; am[l][2][2] = '0;
        end
        6: am[l][0][3] = -sjafk_pkg::AP4;
        7: am[l][1][3] = sjafk_pkg::DP5;
        8: begin
          am[l][0][0] = c4; am[l][0][1] = -s4;
          am[l][1][1] = '0; am[l][1][2] = sjafk_pkg::ONE; am[l][1][3] = sjafk_pkg::DP6;
          am[l][2][0] = -s4; am[l][2][1] = -c4; am[l][2][2] = '0;
        end
        9: begin
          am[l][0][0] = c5; am[l][0][1] = -s5;
          am[l][1][1] = '0; am[l][1][2] = -sjafk_pkg::ONE;
          am[l][2][0] = s5; am[l][2][1] = c5; am[l][2][2] = '0;
        end
        10: begin
          am[l][0][0] = c6; am[l][0][1] = -s6; am[l][0][3] = sjafk_pkg::AP6;
          am[l][1][1] = '0; am[l][1][2] = -sjafk_pkg::ONE;
          am[l][2][0] = s6; am[l][2][1] = c6; am[l][2][2] = '0;
        end
        11: am[l][2][3] = sjafk_pkg::DP7;
        default: begin
          am[l][0][0] = sjafk_pkg::HS2; am[l][0][1] = sjafk_pkg::HS2;
          am[l][1][0] = -sjafk_pkg::HS2; am[l][1][1] = sjafk_pkg::HS2;
          am[l][2][3] = sjafk_pkg::FLIFT;
        end
      endcase
    end
    sjafk_link_cell u_link (
      .clk (clk), .rst (rst), .vin (lv[l]), .tin (tm[l]), .ain (am[l]),
      .vout(lv[l+1]), .tout(tm[l+1])
    );
  end

  function automatic logic signed [15:0] sat(input logic signed [31:0] v);
    logic signed [31:0] q;
    q = (v + 32'sd8192) >>> 14;
    if (q > 32'sd32767) return 16'sh7fff;
    if (q < -32'sd32768) return 16'sh8000;
    return q[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lv[NL];
    end
  end

  always_ff @(posedge clk) begin
    pose.rot_xx <= sat(tm[NL][0][0]);
    pose.rot_xy <= sat(tm[NL][0][1]);
    pose.rot_xz <= sat(tm[NL][0][2]);
    pose.rot_yx <= sat(tm[NL][1][0]);
    pose.rot_yy <= sat(tm[NL][1][1]);
    pose.rot_yz <= sat(tm[NL][1][2]);
    pose.rot_zx <= sat(tm[NL][2][0]);
    pose.rot_zy <= sat(tm[NL][2][1]);
    pose.rot_zz <= sat(tm[NL][2][2]);
    pose.pos_x <= sat(tm[NL][0][3]);
    pose.pos_y <= sat(tm[NL][1][3]);
    pose.pos_z <= sat(tm[NL][2][3]);
  end

  a_busy_low: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    cv[sjafk_pkg::NSTEP] |-> ##27 done) else $error("beat lost in link chain");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(lv[NL])) else $error("spurious done");

endmodule
